// File: rtl/substring_position_finder_macros.svh
// Assertion macros shared by the substring position finder modules.
`ifndef SUBSTRING_POSITION_FINDER_MACROS_SVH
`define SUBSTRING_POSITION_FINDER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SSF_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("substring finder: invariant violated");

// Check a consequence in the same cycle as its cause.
`define SSF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("substring finder: same-cycle check failed");

// Check a consequence in the cycle after its cause.
`define SSF_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("substring finder: next-cycle check failed");

`endif

// File: rtl/ssf_pkg.sv
// Package with field widths, register codes and shared types of the substring finder.
package ssf_pkg;

	localparam int unsigned BYTE_W         = 8;
	localparam int unsigned PAT_WORD_W     = 64;
	localparam int unsigned PAT_WORD_BYTES = 8;
	localparam int unsigned PAT_BYTES      = 16;
	localparam int unsigned PAT_IDX_W      = 4;
	localparam int unsigned PAT_LEN_W      = 5;
	localparam int unsigned POS_W          = 13;
	localparam int unsigned CFG_IDX_W      = 2;
	localparam int unsigned CFG_DATA_W     = 64;
	localparam int unsigned START_RESET    = 1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAT_LOW  = 2'd0,
		CFG_PAT_HIGH = 2'd1,
		CFG_PAT_LEN  = 2'd2,
		CFG_START    = 2'd3
	} cfg_idx_t;

	// Register file contents seen by the scanner
	typedef struct packed {
		logic [PAT_WORD_W-1:0] pat_low;
		logic [PAT_WORD_W-1:0] pat_high;
		logic [PAT_LEN_W-1:0]  pat_len;
		logic [POS_W-1:0]      start_pos;
	} cfg_regs_t;

	// Result beat handed from the scanner to the output register
	typedef struct packed {
		logic             valid;
		logic [POS_W-1:0] found;
		logic             too_long;
	} result_t;

endpackage

// File: rtl/ssf_if.sv
// Channel interfaces of the substring finder: text input, result output, register writes.
interface ssf_text_if;
	logic                       valid;
	logic                       ready;
	logic [ssf_pkg::BYTE_W-1:0] text_byte;
	logic                       byte_valid;
	logic                       last_item;

	modport source(output valid, text_byte, byte_valid, last_item, input ready);
	modport sink(input valid, text_byte, byte_valid, last_item, output ready);
endinterface

interface ssf_result_if;
	logic                      valid;
	logic                      ready;
	logic [ssf_pkg::POS_W-1:0] found_position;
	logic                      text_too_long;

	modport source(output valid, found_position, text_too_long, input ready);
	modport sink(input valid, found_position, text_too_long, output ready);
endinterface

interface ssf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ssf_pkg::CFG_IDX_W-1:0]  index;
	logic [ssf_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/ssf_cfg.sv
// Configuration register file of the substring finder.
module ssf_cfg (
	input  logic               clk,
	input  logic               arst_n,
	ssf_cfg_if.sink            cfg,
	output ssf_pkg::cfg_regs_t regs
);

	ssf_pkg::cfg_regs_t regs_q;

	// Always take register writes
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Decode the index and update one register per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.pat_low   <= '0;
			regs_q.pat_high  <= '0;
			regs_q.pat_len   <= '0;
			regs_q.start_pos <= ssf_pkg::POS_W'(ssf_pkg::START_RESET);
		end else if (cfg.valid && cfg.ready) begin
			unique case (ssf_pkg::cfg_idx_t'(cfg.index))
				ssf_pkg::CFG_PAT_LOW: begin
					regs_q.pat_low <= cfg.data[ssf_pkg::PAT_WORD_W-1:0];
				end
				ssf_pkg::CFG_PAT_HIGH: begin
					regs_q.pat_high <= cfg.data[ssf_pkg::PAT_WORD_W-1:0];
				end
				ssf_pkg::CFG_PAT_LEN: begin
					regs_q.pat_len <= cfg.data[ssf_pkg::PAT_LEN_W-1:0];
				end
				ssf_pkg::CFG_START: begin
					regs_q.start_pos <= cfg.data[ssf_pkg::POS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: rtl/ssf_scan.sv
// Input stage, byte window, pattern compare and search state of the substring finder.
`include "substring_position_finder_macros.svh"

module ssf_scan #(
	parameter int unsigned PATTERN_MAX = 16,
	parameter int unsigned TEXT_MAX    = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	ssf_text_if.sink           text_in,
	input  ssf_pkg::cfg_regs_t regs,
	input  logic               out_busy,
	output ssf_pkg::result_t   res
);

	localparam int unsigned CNT_W = $clog2(TEXT_MAX + 1);
	localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int unsigned CMP_W = (CNT_W > ssf_pkg::POS_W) ? CNT_W : ssf_pkg::POS_W;

	// Input stage
	logic                       valid_s1;
	logic [ssf_pkg::BYTE_W-1:0] byte_s1;
	logic                       bvalid_s1;
	logic                       last_s1;
	logic                       advance;

	// Search state
	logic [ssf_pkg::BYTE_W-1:0] win_q [PATTERN_MAX];
	logic [CNT_W-1:0]           cnt_q;
	logic [CNT_W-1:0]           fmp_q;
	logic                       match_q;
	logic                       zero_q;
	logic                       ovf_q;

	// Next-state and compare signals
	logic [ssf_pkg::BYTE_W-1:0] pat_b [ssf_pkg::PAT_BYTES];
	logic [ssf_pkg::BYTE_W-1:0] win_n [PATTERN_MAX];
	logic [LEN_W-1:0]           len_used;
	logic                       win_hit;
	logic                       take;
	logic                       shift;
	logic [CNT_W-1:0]           pos;
	logic [CNT_W-1:0]           mstart;
	logic [CMP_W-1:0]           start_w;
	logic [CNT_W-1:0]           cnt_d;
	logic [CNT_W-1:0]           fmp_d;
	logic                       match_d;
	logic                       zero_d;
	logic                       ovf_d;

	// Hold a final beat while the output register is still full
	assign advance       = valid_s1 && !(last_s1 && out_busy);
	assign text_in.ready = !valid_s1 || advance;

	// Load the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.valid && text_in.ready) begin
			byte_s1   <= text_in.text_byte;
			bvalid_s1 <= text_in.byte_valid;
			last_s1   <= text_in.last_item;
		end
	end

	// Unpack pattern bytes, clamp the length, build the shifted window
	always_comb begin
		for (int k = 0; k < ssf_pkg::PAT_WORD_BYTES; k++) begin
			pat_b[k] = regs.pat_low[k*ssf_pkg::BYTE_W +: ssf_pkg::BYTE_W];
			pat_b[k+ssf_pkg::PAT_WORD_BYTES] =
				regs.pat_high[k*ssf_pkg::BYTE_W +: ssf_pkg::BYTE_W];
		end
		if (regs.pat_len > ssf_pkg::PAT_LEN_W'(PATTERN_MAX)) begin
			len_used = LEN_W'(PATTERN_MAX);
		end else begin
			len_used = LEN_W'(regs.pat_len);
		end
		win_n[0] = byte_s1;
		for (int i = 1; i < PATTERN_MAX; i++) begin
			win_n[i] = win_q[i-1];
		end
	end

	// Compare the window against the pattern ending at the newest byte
	always_comb begin
		logic [ssf_pkg::PAT_LEN_W-1:0] idx;
		win_hit = 1'b1;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			idx = ssf_pkg::PAT_LEN_W'(len_used) - ssf_pkg::PAT_LEN_W'(i) -
				ssf_pkg::PAT_LEN_W'(1);
			if (LEN_W'(i) < len_used &&
				win_n[i] != pat_b[idx[ssf_pkg::PAT_IDX_W-1:0]]) begin
				win_hit = 1'b0;
			end
		end
	end

	// Advance the search state by one character
	always_comb begin
		take    = advance && bvalid_s1;
		shift   = 1'b0;
		pos     = cnt_q + CNT_W'(1);
		mstart  = pos - CNT_W'(len_used) + CNT_W'(1);
		start_w = CMP_W'(regs.start_pos);
		cnt_d   = cnt_q;
		fmp_d   = fmp_q;
		match_d = match_q;
		zero_d  = zero_q;
		ovf_d   = ovf_q;
		if (take) begin
			if (cnt_q == CNT_W'(TEXT_MAX)) begin
				ovf_d = 1'b1;
			end else begin
				cnt_d = pos;
				shift = 1'b1;
				if (CMP_W'(pos) >= start_w) begin
					if (byte_s1 == '0) begin
						zero_d = 1'b1;
					end else if (!zero_q && !match_q && len_used != '0 &&
						pos >= CNT_W'(len_used) && CMP_W'(mstart) >= start_w &&
						win_hit) begin
						match_d = 1'b1;
						fmp_d   = mstart;
					end
				end
			end
		end
	end

	// Form the result on the final beat
	always_comb begin
		res.valid    = advance && last_s1;
		res.found    = '0;
		res.too_long = 1'b0;
		if (ovf_d) begin
			res.too_long = 1'b1;
		end else if (regs.start_pos == '0 || start_w > CMP_W'(cnt_d)) begin
			res.found = '0;
		end else if (len_used == '0) begin
			res.found = regs.start_pos;
		end else if (match_d) begin
			res.found = ssf_pkg::POS_W'(fmp_d);
		end
	end

	// Update state; drop it all after the final beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			fmp_q   <= '0;
			match_q <= 1'b0;
			zero_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (advance && last_s1) begin
			cnt_q   <= '0;
			fmp_q   <= '0;
			match_q <= 1'b0;
			zero_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			cnt_q   <= cnt_d;
			fmp_q   <= fmp_d;
			match_q <= match_d;
			zero_q  <= zero_d;
			ovf_q   <= ovf_d;
		end
	end

	// Shift the window on each counted character
	always_ff @(posedge clk) begin
		if (shift) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				win_q[i] <= win_n[i];
			end
		end
	end

	`SSF_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(TEXT_MAX))
	`SSF_ASSERT_IMP(a_ovf_full, ovf_q, cnt_q == CNT_W'(TEXT_MAX))
	`SSF_ASSERT_IMP(a_match_pos, match_q, fmp_q != '0 && fmp_q <= cnt_q)
	`SSF_ASSERT_NXT(a_last_held, valid_s1 && last_s1 && out_busy, valid_s1 && last_s1)

endmodule

// File: rtl/substring_position_finder.sv
// Top level of the streaming substring position finder.
//
// Streams a text one byte per beat on text_in and, on the beat marked last_item,
// returns one result beat on result_out: the 1-based position of the first
// occurrence of the configured pattern (up to PATTERN_MAX bytes) that starts at
// or after start_position, or 0 if none, if start_position is 0 or lies past the
// end of the text. An empty pattern returns start_position; a zero text byte at
// or after start_position ends matching; texts longer than TEXT_MAX characters
// give 0 with text_too_long set. Each beat is registered, the window compare and
// state update run in combinational logic, and the result lands in an output
// register, so a new beat is accepted every cycle; only a final beat waits while
// a previous result is still held. Registers are written on cfg (index 0 pattern
// bytes 1-8, 1 bytes 9-16, 2 length, 3 start); the user must write them only
// between texts, which the block itself does not enforce.
`include "substring_position_finder_macros.svh"

module substring_position_finder #(
	parameter int unsigned PATTERN_MAX = 16,
	parameter int unsigned TEXT_MAX    = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	ssf_text_if.sink     text_in,
	ssf_result_if.source result_out,
	ssf_cfg_if.sink      cfg
);

	ssf_pkg::cfg_regs_t        regs;
	ssf_pkg::result_t          res;
	logic                      out_valid_q;
	logic [ssf_pkg::POS_W-1:0] found_q;
	logic                      too_long_q;
	logic                      out_busy;

	ssf_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	ssf_scan #(
		.PATTERN_MAX (PATTERN_MAX),
		.TEXT_MAX    (TEXT_MAX)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in),
		.regs     (regs),
		.out_busy (out_busy),
		.res      (res)
	);

	assign out_busy = out_valid_q && !result_out.ready;

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			found_q    <= res.found;
			too_long_q <= res.too_long;
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.found_position = found_q;
	assign result_out.text_too_long  = too_long_q;

	`SSF_ASSERT_IMP(a_no_overwrite, res.valid, !out_busy)

endmodule

// File: test/substring_position_finder_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the substring position finder: stream texts, predict positions.
module substring_position_finder_test;

	localparam int unsigned TEXT_LIMIT    = 4096;
	localparam int unsigned PAT_LIMIT     = 16;
	localparam int unsigned ITEM_TARGET   = 2000;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned STALL_LIMIT   = 3000;
	localparam int unsigned REPORT_LIMIT  = 10;
	localparam int unsigned PRESSURE_PASS = 3;
	localparam logic [ssf_pkg::BYTE_W-1:0] ALPHA_FIRST = 8'h61;

	typedef struct packed {
		logic [ssf_pkg::POS_W-1:0] pos;
		logic                      too_long;
	} answer_t;

	// Answer typed into the directed table, or left to the predictor
	typedef struct packed {
		logic    given;
		answer_t ans;
	} typed_answer_t;

	typedef struct packed {
		logic [ssf_pkg::BYTE_W-1:0] data;
		logic                       valid;
		logic                       last;
	} beat_t;

	// One directed text: optional register load, up to 8 characters (first one leftmost),
	// a mask of characters sent as ignored fillers, and an optional blank closing beat.
	typedef struct packed {
		logic                             reload;
		logic [2*ssf_pkg::PAT_WORD_W-1:0] pat;
		logic [ssf_pkg::PAT_LEN_W-1:0]    plen;
		logic [ssf_pkg::POS_W-1:0]        start;
		logic [63:0]                      chars;
		logic [3:0]                       n;
		logic [7:0]                       skips;
		logic                             tail_blank;
		logic                             given;
		logic [ssf_pkg::POS_W-1:0]        pos;
	} probe_t;

	typedef enum logic [1:0] {SINK_OPEN, SINK_LIGHT, SINK_HEAVY} sink_mode_t;

	//                   reload pat        plen    start      chars       n    skips  blank given pos
	localparam probe_t PROBES [14] = '{
		'{1'b0, 128'h0,    5'd0,  13'd0,    "a",        4'd1, 8'h00, 1'b0, 1'b1, 13'd1},
		'{1'b1, 128'h6261, 5'd2,  13'd1,    "xab",      4'd3, 8'h00, 1'b0, 1'b0, 13'd0},
		'{1'b1, 128'h6261, 5'd2,  13'd0,    "ab",       4'd2, 8'h00, 1'b0, 1'b1, 13'd0},
		'{1'b1, 128'h6261, 5'd2,  13'd5,    "ab",       4'd2, 8'h00, 1'b0, 1'b1, 13'd0},
		'{1'b1, 128'h0,    5'd0,  13'd2,    "xy",       4'd2, 8'h00, 1'b0, 1'b1, 13'd2},
		'{1'b1, 128'h62,   5'd1,  13'd1,    64'h0062,   4'd2, 8'h00, 1'b0, 1'b1, 13'd0},
		'{1'b1, 128'h62,   5'd1,  13'd2,    64'h0062,   4'd2, 8'h00, 1'b0, 1'b0, 13'd0},
		'{1'b1, 128'h6261, 5'd2,  13'd1,    "axb",      4'd3, 8'h02, 1'b0, 1'b0, 13'd0},
		'{1'b1, 128'h6261, 5'd2,  13'd1,    64'h0,      4'd0, 8'h00, 1'b1, 1'b1, 13'd0},
		'{1'b1, 128'hFF,   5'd1,  13'd1,    64'h01FF,   4'd2, 8'h00, 1'b0, 1'b0, 13'd0},
		'{1'b1, 128'h0061, 5'd2,  13'd1,    64'h6100,   4'd2, 8'h00, 1'b0, 1'b1, 13'd0},
		'{1'b1, 128'h6261, 5'd2,  13'd2,    "abab",     4'd4, 8'h00, 1'b1, 1'b0, 13'd0},
		'{1'b1, 128'h6261, 5'd31, 13'd1,    "ab",       4'd2, 8'h00, 1'b0, 1'b1, 13'd0},
		'{1'b1, 128'h0,    5'd0,  13'd4097, "a",        4'd1, 8'h00, 1'b0, 1'b1, 13'd0}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	ssf_text_if   text_ch();
	ssf_result_if result_ch();
	ssf_cfg_if    cfg_ch();

	substring_position_finder #(
		.PATTERN_MAX(PAT_LIMIT),
		.TEXT_MAX(TEXT_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.text_in(text_ch),
		.result_out(result_ch),
		.cfg(cfg_ch)
	);

	wire text_beat   = arst_n && text_ch.valid && text_ch.ready;
	wire result_beat = arst_n && result_ch.valid && result_ch.ready;
	wire cfg_beat    = arst_n && cfg_ch.valid && cfg_ch.ready;

	// Predictor copy of the registers and of the scan state
	logic [ssf_pkg::PAT_WORD_W-1:0] pat_lo_q  = '0;
	logic [ssf_pkg::PAT_WORD_W-1:0] pat_hi_q  = '0;
	logic [ssf_pkg::PAT_LEN_W-1:0]  pat_len_q = '0;
	logic [ssf_pkg::POS_W-1:0]      start_q   = ssf_pkg::POS_W'(ssf_pkg::START_RESET);
	logic [ssf_pkg::BYTE_W-1:0]     window_q [ssf_pkg::PAT_BYTES];
	int unsigned                    chars_q     = 0;
	int unsigned                    match_pos_q = 0;
	bit                             matched_q   = 1'b0;
	bit                             nul_q       = 1'b0;
	bit                             overflow_q  = 1'b0;

	answer_t       answers_due [$];
	typed_answer_t typed_q [$];
	beat_t         text_q [$];

	logic [2*ssf_pkg::PAT_WORD_W-1:0] cur_pat = '0;
	logic [ssf_pkg::PAT_LEN_W-1:0]    cur_len = '0;
	int unsigned             mismatches    = 0;
	int unsigned             items_sent    = 0;
	int unsigned             burst_left    = 0;
	int unsigned             quiet_cycles  = 0;
	int unsigned             hold_requests = 0;
	int unsigned             holds_served  = 0;
	bit                      steady        = 1'b0;

	initial begin
		foreach (window_q[i]) window_q[i] = '0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned used_len();
		return (pat_len_q > PAT_LIMIT) ? PAT_LIMIT : int'(pat_len_q);
	endfunction

	function automatic logic [ssf_pkg::BYTE_W-1:0] pat_byte(int unsigned k);
		logic [2*ssf_pkg::PAT_WORD_W-1:0] both;
		both = {pat_hi_q, pat_lo_q};
		return both[8*k +: 8];
	endfunction

	function automatic void clear_scan();
		foreach (window_q[i]) window_q[i] = '0;
		chars_q     = 0;
		match_pos_q = 0;
		matched_q   = 1'b0;
		nul_q       = 1'b0;
		overflow_q  = 1'b0;
	endfunction

	// Shift one character into the window and look for a pattern ending on it
	function automatic void take_byte(logic [ssf_pkg::BYTE_W-1:0] b);
		int unsigned n;
		bit hit;
		if (chars_q >= TEXT_LIMIT) begin
			overflow_q = 1'b1;
			return;
		end
		chars_q++;
		for (int i = ssf_pkg::PAT_BYTES - 1; i > 0; i--) window_q[i] = window_q[i-1];
		window_q[0] = b;
		if (chars_q < start_q) return;
		if (b == '0) begin
			nul_q = 1'b1;
			return;
		end
		if (nul_q || matched_q) return;
		n = used_len();
		if (n == 0 || chars_q < n || chars_q - n + 1 < start_q) return;
		hit = 1'b1;
		for (int i = 0; i < n; i++) if (window_q[i] != pat_byte(n - 1 - i)) hit = 1'b0;
		if (hit) begin
			matched_q   = 1'b1;
			match_pos_q = chars_q - n + 1;
		end
	endfunction

	// Work out the answer for the text just ended, then clear the scan state
	function automatic answer_t close_text();
		answer_t a;
		a.too_long = overflow_q;
		a.pos      = '0;
		if (!overflow_q && start_q != 0 && start_q <= chars_q) begin
			if (used_len() == 0) a.pos = start_q;
			else if (matched_q) a.pos = ssf_pkg::POS_W'(match_pos_q);
		end
		clear_scan();
		return a;
	endfunction

	function automatic void log_miss(string what, int unsigned want, int unsigned got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
	endfunction

	// Track register writes
	always @(posedge clk) begin
		if (cfg_beat === 1'b1) begin
			case (ssf_pkg::cfg_idx_t'(cfg_ch.index))
			ssf_pkg::CFG_PAT_LOW:  pat_lo_q = cfg_ch.data;
			ssf_pkg::CFG_PAT_HIGH: pat_hi_q = cfg_ch.data;
			ssf_pkg::CFG_PAT_LEN:  pat_len_q = cfg_ch.data[ssf_pkg::PAT_LEN_W-1:0];
			ssf_pkg::CFG_START:    start_q = cfg_ch.data[ssf_pkg::POS_W-1:0];
			default:               ;
			endcase
		end
	end

	// Predict on every accepted text beat
	always @(posedge clk) begin : text_watch
		answer_t a;
		typed_answer_t t;
		if (text_beat === 1'b1) begin
			if (text_ch.byte_valid) take_byte(text_ch.text_byte);
			if (text_ch.last_item) begin
				a = close_text();
				t = typed_q.pop_front();
				answers_due.push_back(t.given ? t.ans : a);
			end
		end
	end

	// Compare every result beat with the oldest answer due
	always @(posedge clk) begin : result_watch
		answer_t want;
		if (result_beat === 1'b1) begin
			if (answers_due.size() == 0) begin
				log_miss("result with none due", 0, result_ch.found_position);
			end else begin
				want = answers_due.pop_front();
				if (result_ch.found_position !== want.pos)
					log_miss("found_position", want.pos, result_ch.found_position);
				if (result_ch.text_too_long !== want.too_long)
					log_miss("text_too_long", want.too_long, result_ch.text_too_long);
			end
		end
	end

	// Abort when no beat moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || text_beat === 1'b1 || result_beat === 1'b1 || cfg_beat === 1'b1) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", quiet_cycles);
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result sink: random stall modes, plus a long hold-off on request
	initial begin : result_sink
		int unsigned hold_left, mode_left;
		sink_mode_t mode;
		result_ch.ready = 1'b0;
		hold_left = 0;
		mode_left = 0;
		mode = SINK_OPEN;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = sink_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(16, 160);
				end
				mode_left--;
				case (mode)
				SINK_OPEN:  result_ch.ready <= 1'b1;
				SINK_LIGHT: result_ch.ready <= ($urandom_range(0, 3) != 0);
				default:    result_ch.ready <= ($urandom_range(0, 2) == 0);
				endcase
			end
		end
	end

	// Offer one text beat, in bursts with random gaps, and hold it until taken
	task automatic send_beat(beat_t bt);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady ? 0 : $urandom_range(0, 8);
			if (gap != 0) begin
				text_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		text_ch.valid      <= 1'b1;
		text_ch.text_byte  <= bt.data;
		text_ch.byte_valid <= bt.valid;
		text_ch.last_item  <= bt.last;
		@(posedge clk);
		while (text_beat !== 1'b1) @(posedge clk);
		@(negedge clk);
		if (bt.valid) items_sent++;
	endtask

	task automatic send_text(typed_answer_t t);
		typed_q.push_back(t);
		foreach (text_q[i]) send_beat(text_q[i]);
	endtask

	task automatic write_reg(ssf_pkg::cfg_idx_t idx, logic [ssf_pkg::CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (cfg_beat !== 1'b1) @(posedge clk);
		@(negedge clk);
	endtask

	// Load all four registers; unused upper data bits carry noise
	task automatic load_search(logic [2*ssf_pkg::PAT_WORD_W-1:0] pat,
			logic [ssf_pkg::PAT_LEN_W-1:0] len, logic [ssf_pkg::POS_W-1:0] start);
		logic [ssf_pkg::CFG_DATA_W-1:0] noise;
		noise = {$urandom, $urandom};
		write_reg(ssf_pkg::CFG_PAT_LOW, pat[ssf_pkg::PAT_WORD_W-1:0]);
		write_reg(ssf_pkg::CFG_PAT_HIGH, pat[2*ssf_pkg::PAT_WORD_W-1:ssf_pkg::PAT_WORD_W]);
		write_reg(ssf_pkg::CFG_PAT_LEN, {noise[ssf_pkg::CFG_DATA_W-1:ssf_pkg::PAT_LEN_W], len});
		write_reg(ssf_pkg::CFG_START, {noise[ssf_pkg::CFG_DATA_W-1:ssf_pkg::POS_W], start});
		cfg_ch.valid <= 1'b0;
		cur_pat = pat;
		cur_len = len;
	endtask

	// Drop valid and wait until every answer is in and the pipeline is quiet
	task automatic settle_all();
		text_ch.valid <= 1'b0;
		while (answers_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [2*ssf_pkg::PAT_WORD_W-1:0] random_pattern();
		logic [2*ssf_pkg::PAT_WORD_W-1:0] pat;
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0) pat = '1;
		else if (r < 5) pat = {$urandom, $urandom, $urandom, $urandom};
		else for (int j = 0; j < ssf_pkg::PAT_BYTES; j++)
			pat[8*j +: 8] = ALPHA_FIRST + 8'($urandom_range(0, 2));
		return pat;
	endfunction

	// Build a text of n characters, mostly over a small alphabet, with planted copies of the pattern
	function automatic void compose_text(int unsigned n, bit with_nul);
		int unsigned k, r, plen;
		beat_t bt;
		text_q.delete();
		k = 0;
		plen = (cur_len > PAT_LIMIT) ? PAT_LIMIT : int'(cur_len);
		while (k < n) begin
			r = $urandom_range(0, 99);
			bt = '{data: ALPHA_FIRST + 8'($urandom_range(0, 2)), valid: 1'b1, last: 1'b0};
			if (r < 6 && plen != 0) begin
				for (int j = 0; j < plen && k < n; j++) begin
					bt.data = cur_pat[8*j +: 8];
					text_q.push_back(bt);
					k++;
				end
			end else begin
				if (r < 9) begin
					bt.valid = 1'b0;
					bt.data = 8'($urandom);
				end else if (r < 10 && with_nul) begin
					bt.data = '0;
				end else if (r < 18) begin
					bt.data = 8'($urandom);
				end
				text_q.push_back(bt);
				if (bt.valid) k++;
			end
		end
		if (n == 0 || $urandom_range(0, 3) == 0) begin
			bt = '{data: 8'($urandom), valid: 1'b0, last: 1'b1};
			text_q.push_back(bt);
		end else begin
			bt = text_q.pop_back();
			bt.last = 1'b1;
			text_q.push_back(bt);
		end
	endfunction

	initial begin : stimulus
		probe_t p;
		beat_t bt;
		int unsigned r, n, texts, pass_no;
		logic [ssf_pkg::PAT_LEN_W-1:0] len;
		logic [ssf_pkg::POS_W-1:0] start;

		text_ch.valid      = 1'b0;
		text_ch.text_byte  = '0;
		text_ch.byte_valid = 1'b0;
		text_ch.last_item  = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = ssf_pkg::CFG_PAT_LOW;
		cfg_ch.data        = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Directed table
		foreach (PROBES[i]) begin
			p = PROBES[i];
			if (p.reload) begin
				settle_all();
				load_search(p.pat, p.plen, p.start);
			end
			text_q.delete();
			for (int k = 0; k < p.n; k++) begin
				bt.data  = p.chars[8*(p.n - 1 - k) +: 8];
				bt.valid = !p.skips[k];
				bt.last  = (k == p.n - 1) && !p.tail_blank;
				text_q.push_back(bt);
			end
			if (p.tail_blank) begin
				bt = '{data: 8'hFF, valid: 1'b0, last: 1'b1};
				text_q.push_back(bt);
			end
			send_text('{given: p.given, ans: '{pos: p.pos, too_long: 1'b0}});
		end

		// Random passes: new registers, then a handful of texts
		pass_no = 0;
		while (items_sent < ITEM_TARGET) begin
			settle_all();
			r = $urandom_range(0, 9);
			case (r)
			0:       len = '0;
			1:       len = ssf_pkg::PAT_LEN_W'($urandom_range(PAT_LIMIT + 1, 31));
			2:       len = ssf_pkg::PAT_LEN_W'(PAT_LIMIT);
			default: len = ssf_pkg::PAT_LEN_W'($urandom_range(1, 6));
			endcase
			r = $urandom_range(0, 9);
			case (r)
			0:       start = '0;
			1:       start = ssf_pkg::POS_W'($urandom_range(0, 8191));
			2:       start = ssf_pkg::POS_W'(TEXT_LIMIT + 1);
			default: start = ssf_pkg::POS_W'($urandom_range(1, 10));
			endcase
			load_search(random_pattern(), len, start);
			steady = ($urandom_range(0, 3) == 0);
			texts = $urandom_range(1, 6);
			// Hold the result side off while short texts keep coming
			if (pass_no == PRESSURE_PASS) begin
				hold_requests++;
				steady = 1'b1;
				texts = 20;
			end
			repeat (texts) begin
				if (pass_no == PRESSURE_PASS) n = $urandom_range(1, 4);
				else if ($urandom_range(0, 9) == 0) n = $urandom_range(31, 120);
				else n = $urandom_range(0, 30);
				compose_text(n, 1'b1);
				send_text('{given: 1'b0, ans: '0});
			end
			pass_no++;
		end

		// A text that just fills the limit and one that runs past it
		steady = 1'b0;
		for (int extra = 0; extra <= 1; extra++) begin
			settle_all();
			load_search(random_pattern(), ssf_pkg::PAT_LEN_W'(3),
				ssf_pkg::POS_W'(TEXT_LIMIT - 12 + $urandom_range(0, 12)));
			compose_text(TEXT_LIMIT + extra, 1'b0);
			send_text('{given: 1'b0, ans: '0});
		end

		settle_all();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
